// ----- design/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared constants, stage record and long-division step for the converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int COMP_W      = 8;
    localparam int HUE_W       = 15;
    localparam int DIV_Q       = 12;
    localparam int DIV_W       = COMP_W + DIV_Q;
    localparam int STEPS       = 2;
    localparam int DIV_STAGES  = DIV_Q / STEPS;
    localparam int PIPE_DEPTH  = DIV_STAGES + 2;

    localparam logic [HUE_W-1:0] BASE_RED   = 15'd0;
    localparam logic [HUE_W-1:0] BASE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0] BASE_BLUE  = 15'd15360;
    localparam logic [15:0]      HUE_FULL   = 16'd23040;

    typedef struct packed {
        logic [HUE_W-1:0]  base;
        logic              neg;
        logic              undef;
        logic [COMP_W-1:0] mx;
        logic [COMP_W-1:0] delta;
        logic [DIV_W-1:0]  hx;
        logic [DIV_W-1:0]  sx;
    } t_pix;

    function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] x,
                                                  input logic [COMP_W-1:0] d);
        logic [COMP_W:0] top;
        logic            ge;
        logic [COMP_W:0] rem;
        top = {x[DIV_W-1:DIV_Q], x[DIV_Q-1]};
        ge  = (top >= {1'b0, d});
        rem = ge ? (top - {1'b0, d}) : top;
        return {rem[COMP_W-1:0], x[DIV_Q-2:0], ge};
    endfunction

    function automatic logic [DIV_W-1:0] div_stage(input logic [DIV_W-1:0] x,
                                                   input logic [COMP_W-1:0] d);
        logic [DIV_W-1:0] v;
        v = x;
        for (int s = 0; s < STEPS; s++) begin
            v = div_step(v, d);
        end
        return v;
    endfunction

endpackage

// ----- design/rgb_to_hsv_converter_core.sv -----
// A pixel passes through the front register, the divider stages and the output register.
// Throughput: one pixel per cycle while i_stall is low; the divider is a 6-stage pipeline
// retiring 2 quotient bits per stage for hue and saturation in parallel.
// Each stage advances when empty or when the stage after it advances.
// Reset: synchronous, active low; clears all stage valid bits.
// ----------------------------------------------------------------------------
// RGB to HSV converter core
// Pipelined conversion of 8-bit RGB pixels to hue, saturation and value.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core
    import rhc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [COMP_W-1:0] i_red,
    input  logic [COMP_W-1:0] i_green,
    input  logic [COMP_W-1:0] i_blue,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [HUE_W-1:0]  o_hue,
    output logic [COMP_W-1:0] o_saturation,
    output logic [COMP_W-1:0] o_brightness,
    output logic              o_hue_undefined
);

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH:0]   ready;
    t_pix                  r_pix [0:DIV_STAGES];
    t_pix                  n_pix [1:DIV_STAGES];
    t_pix                  n_front;
    logic [HUE_W-1:0]      r_hue;
    logic [COMP_W-1:0]     r_sat;
    logic [COMP_W-1:0]     r_bright;
    logic                  r_undef;
    logic [HUE_W-1:0]      n_hue;

    logic              red_max;
    logic              green_max;
    logic [COMP_W-1:0] mx;
    logic [COMP_W-1:0] mn;
    logic [COMP_W-1:0] dp;
    logic [COMP_W-1:0] dq;
    logic [COMP_W:0]   dsub;
    logic [COMP_W:0]   dabs;
    logic [DIV_W-1:0]  amag;
    logic [DIV_W-1:0]  dlt;

    t_pix              fin;
    logic [DIV_Q:0]    qmag;
    logic [15:0]       hue_s;

    always_comb begin
        ready[PIPE_DEPTH] = !i_stall;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            ready[k] = !r_vld[k] || ready[k+1];
        end
    end

    assign o_stall = !ready[0];

    always_comb begin
        red_max   = (i_red >= i_green) && (i_red >= i_blue);
        green_max = !red_max && (i_green >= i_blue);
        mx = (i_red > i_green) ? i_red : i_green;
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue > mx) begin
            mx = i_blue;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
        if (red_max) begin
            dp = i_green;
            dq = i_blue;
            n_front.base = BASE_RED;
        end else if (green_max) begin
            dp = i_blue;
            dq = i_red;
            n_front.base = BASE_GREEN;
        end else begin
            dp = i_red;
            dq = i_green;
            n_front.base = BASE_BLUE;
        end
        dsub = {1'b0, dp} - {1'b0, dq};
        dabs = dsub[COMP_W] ? (~dsub + 1'b1) : dsub;
        amag = {{DIV_Q{1'b0}}, dabs[COMP_W-1:0]};
        n_front.neg   = dsub[COMP_W];
        n_front.mx    = mx;
        n_front.delta = mx - mn;
        n_front.undef = (mx == mn);
        dlt = {{DIV_Q{1'b0}}, n_front.delta};
        n_front.hx = (amag << 12) - (amag << 8);
        n_front.sx = (dlt << 8) - dlt;
    end

    always_comb begin
        for (int k = 1; k <= DIV_STAGES; k++) begin
            n_pix[k]    = r_pix[k-1];
            n_pix[k].hx = div_stage(r_pix[k-1].hx, r_pix[k-1].delta);
            n_pix[k].sx = div_stage(r_pix[k-1].sx, r_pix[k-1].mx);
        end
    end

    always_comb begin
        fin   = r_pix[DIV_STAGES];
        qmag  = {1'b0, fin.hx[DIV_Q-1:0]}
              + {{DIV_Q{1'b0}}, (fin.neg && (fin.hx[DIV_W-1:DIV_Q] != '0))};
        if (fin.neg) begin
            hue_s = {1'b0, fin.base} - {3'b000, qmag};
        end else begin
            hue_s = {1'b0, fin.base} + {3'b000, qmag};
        end
        if (hue_s[15]) begin
            hue_s = hue_s + HUE_FULL;
        end
        n_hue = fin.undef ? '0 : hue_s[HUE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ready[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            r_pix[0] <= n_front;
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (ready[k]) begin
                r_pix[k] <= n_pix[k];
            end
        end
        if (ready[PIPE_DEPTH-1]) begin
            r_hue    <= n_hue;
            r_sat    <= fin.undef ? '0 : fin.sx[COMP_W-1:0];
            r_bright <= fin.mx;
            r_undef  <= fin.undef;
        end
    end

    assign o_valid         = r_vld[PIPE_DEPTH-1];
    assign o_hue           = r_hue;
    assign o_saturation    = r_sat;
    assign o_brightness    = r_bright;
    assign o_hue_undefined = r_undef;

`ifndef SYNTHESIS
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hue_undefined |-> (o_hue == '0) && (o_saturation == '0))
        else $error("undefined hue with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_hue} < HUE_FULL))
        else $error("hue out of range");

    a_bright_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hue_undefined |-> (o_brightness != '0))
        else $error("defined hue with zero brightness");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side is free");
`endif

endmodule
